// ----- hdl/mth_pkg.sv -----
package mth_pkg;

  localparam int MAX_HELD = 16;
  localparam int HW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
  localparam int CW = $clog2(MAX_HELD + 1);
  localparam int QD = 2;
  localparam int QAW = $clog2(QD);

  localparam logic [3:0] KIND_OFF = 4'h8;
  localparam logic [3:0] KIND_ON = 4'h9;
  localparam logic [3:0] KIND_AT = 4'hA;
  localparam logic [7:0] STATUS_OFF_MASK = 8'hEF;
  localparam logic [1:0] LEN_FULL = 2'd3;
  localparam logic [1:0] LEN_TWO = 2'd2;
  localparam logic [1:0] LEN_NONE = 2'd0;

  typedef struct packed {
    logic       cmd;
    logic [7:0] status_byte;
    logic [7:0] data_one;
    logic [7:0] data_two;
    logic [1:0] msg_length;
    logic signed [7:0] transpose;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_status;
    logic [7:0] out_data_one;
    logic [7:0] out_data_two;
    logic [1:0] out_length;
    logic       last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_PASS  = 3'd0,
    OP_OFF   = 3'd1,
    OP_ON    = 3'd2,
    OP_AT    = 3'd3,
    OP_XPOSE = 3'd4
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] st;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [1:0] len;
    logic [7:0] xpose;
  } q_entry_t;

  typedef struct packed {
    logic [7:0] note;
    logic [7:0] status;
    logic [7:0] vel;
  } held_t;

  typedef struct packed {
    logic [CW-1:0] held_count;
    logic          busy;
  } bk_status_t;

  function automatic logic [9:0] add_shift(input logic [7:0] note, input logic [7:0] sh);
    return {2'b00, note} + {{2{sh[7]}}, sh};
  endfunction

endpackage

// ----- hdl/mth_front.sv -----
module mth_front (
  input  mth_pkg::in_item_t in_data,
  input  logic              in_fire,
  output mth_pkg::q_entry_t ent,
  output logic              push
);
  import mth_pkg::*;

  logic [3:0] kind;
  logic [7:0] d1m;
  logic [7:0] d2m;

  always_comb begin
    kind = in_data.status_byte[7:4];
    d1m = (in_data.msg_length >= LEN_TWO) ? in_data.data_one : 8'd0;
    d2m = (in_data.msg_length == LEN_FULL) ? in_data.data_two : 8'd0;
    ent.st = in_data.status_byte;
    ent.d1 = d1m;
    ent.d2 = d2m;
    ent.len = in_data.msg_length;
    ent.xpose = in_data.transpose;
    if (in_data.cmd) begin
      ent.op = OP_XPOSE;
    end else if (kind == KIND_OFF || (kind == KIND_ON && d2m == 8'd0)) begin
      ent.op = OP_OFF;
    end else if (kind == KIND_ON) begin
      ent.op = OP_ON;
    end else if (kind == KIND_AT) begin
      ent.op = OP_AT;
    end else begin
      ent.op = OP_PASS;
    end
    // zero-length messages vanish here
    push = in_fire && (in_data.cmd || in_data.msg_length != LEN_NONE);
  end

endmodule

// ----- hdl/mth_queue.sv -----
module mth_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mth_pkg::q_entry_t push_ent,
  input  logic              pop,
  output logic              q_valid,
  output logic              q_full,
  output mth_pkg::q_entry_t q_ent
);
  import mth_pkg::*;

  q_entry_t        buf_r [QD];
  logic [QAW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAW:0]    cnt_r, cnt_nxt;

  assign q_valid = cnt_r != '0;
  assign q_full = cnt_r == (QAW+1)'(QD);
  assign q_ent = buf_r[rp_r];

  always_comb begin
    wp_nxt = push ? wp_r + QAW'(1) : wp_r;
    rp_nxt = pop ? rp_r + QAW'(1) : rp_r;
    cnt_nxt = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= push_ent;
    end
  end

endmodule

// ----- hdl/mth_back.sv -----
module mth_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  mth_pkg::q_entry_t   q_ent,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output mth_pkg::out_item_t  out_data,
  output mth_pkg::bk_status_t status
);
  import mth_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEARCH = 7'b0000010,
    S_SHIFT  = 7'b0000100,
    S_EMIT   = 7'b0001000,
    S_OFFS   = 7'b0010000,
    S_ONS    = 7'b0100000,
    S_FLUSH  = 7'b1000000
  } state_t;

  state_t    state_r, state_nxt;
  q_entry_t  cur_r, cur_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic [7:0] xp_r, xp_nxt;
  logic       pend_v_r, pend_v_nxt, out_valid_r, out_valid_nxt;
  out_item_t  pend_r, pend_nxt, out_r, out_nxt;

  held_t      mem [MAX_HELD];
  held_t      rd_q, wr_data;
  logic       wr_en;
  logic [HW-1:0] wr_addr;

  logic       at_end, out_free, scan_ok, msg_ok;
  logic [7:0] sh;
  logic [9:0] scan_note, msg_note;
  out_item_t  cand, msg_item;

  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign status.held_count = cnt_r;
  assign status.busy = state_r != S_IDLE;

  always_comb begin
    at_end = idx_r == cnt_r;
    out_free = !out_valid_r || !out_stall;
    sh = (state_r == S_OFFS) ? xp_r : cur_r.xpose;
    scan_note = add_shift(rd_q.note, sh);
    scan_ok = scan_note[9:7] == 3'd0;
    cand.out_status = (state_r == S_OFFS) ? (rd_q.status & STATUS_OFF_MASK) : rd_q.status;
    cand.out_data_one = scan_note[7:0];
    cand.out_data_two = (state_r == S_OFFS) ? 8'd0 : rd_q.vel;
    cand.out_length = LEN_FULL;
    cand.last_of_run = 1'b0;
    msg_note = add_shift(cur_r.d1, xp_r);
    msg_ok = (cur_r.op == OP_PASS) || (msg_note[9:7] == 3'd0);
    msg_item.out_status = cur_r.st;
    msg_item.out_data_one = (cur_r.op == OP_PASS) ? cur_r.d1 :
                            ((cur_r.len >= LEN_TWO) ? msg_note[7:0] : 8'd0);
    msg_item.out_data_two = cur_r.d2;
    msg_item.out_length = cur_r.len;
    msg_item.last_of_run = 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt = cur_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    xp_nxt = xp_r;
    pend_v_nxt = pend_v_r;
    pend_nxt = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt = out_r;
    pop = 1'b0;
    wr_en = 1'b0;
    wr_addr = idx_r[HW-1:0];
    wr_data = rd_q;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          cur_nxt = q_ent;
          idx_nxt = '0;
          pend_v_nxt = 1'b0;
          case (q_ent.op)
            OP_OFF, OP_ON: state_nxt = S_SEARCH;
            OP_XPOSE: state_nxt = (q_ent.xpose == xp_r) ? S_IDLE : S_OFFS;
            default: state_nxt = S_EMIT;
          endcase
        end
      end
      S_SEARCH: begin
        if (at_end) begin
          if (cur_r.op == OP_ON && cnt_r < CW'(MAX_HELD)) begin
            wr_en = 1'b1;
            wr_addr = cnt_r[HW-1:0];
            wr_data.note = cur_r.d1;
            wr_data.status = cur_r.st;
            wr_data.vel = cur_r.d2;
            cnt_nxt = cnt_r + CW'(1);
          end
          state_nxt = S_EMIT;
        end else if (rd_q.note == cur_r.d1) begin
          if (cur_r.op == OP_OFF) begin
            idx_nxt = idx_r + CW'(1);
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_EMIT;
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_SHIFT: begin
        // move entry idx down by one
        if (at_end) begin
          cnt_nxt = cnt_r - CW'(1);
          state_nxt = S_EMIT;
        end else begin
          wr_en = 1'b1;
          wr_addr = HW'(idx_r - CW'(1));
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_EMIT: begin
        if (!msg_ok) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = msg_item;
          state_nxt = S_IDLE;
        end
      end
      S_OFFS, S_ONS: begin
        if (at_end) begin
          idx_nxt = '0;
          state_nxt = (state_r == S_OFFS) ? S_ONS : S_FLUSH;
        end else if (scan_ok && pend_v_r && !out_free) begin
          idx_nxt = idx_r;
        end else begin
          if (scan_ok) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_nxt = pend_r;
            end
            pend_v_nxt = 1'b1;
            pend_nxt = cand;
          end
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_FLUSH: begin
        if (!pend_v_r) begin
          xp_nxt = cur_r.xpose;
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = pend_r;
          out_nxt.last_of_run = 1'b1;
          pend_v_nxt = 1'b0;
          xp_nxt = cur_r.xpose;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      idx_r <= '0;
      xp_r <= '0;
      pend_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      xp_r <= xp_nxt;
      pend_v_r <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    pend_r <= pend_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[idx_nxt[HW-1:0]];
  end

endmodule

// ----- hdl/midi_transposer_held_notes.sv -----
// MIDI note transposer with a list of up to 16 held notes. Items enter a
// two-deep queue and are worked off one at a time by an engine that walks
// the held-note memory one entry per clock through its single read port,
// unless a stalled output holds it. A note-on or note-off searches the
// entries and, for a note-off, moves the later entries down; a transpose
// change emits up to 2 * held items, the final one flagged by last_of_run.
// A transpose command equal to the current one emits nothing.
module midi_transposer_held_notes (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mth_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mth_pkg::out_item_t out_data
);
  import mth_pkg::*;

  q_entry_t   f_ent, q_ent;
  logic       push, q_valid, q_full, pop;
  bk_status_t bk_status;

  assign in_stall = q_full;

  mth_front u_front (
    .in_data (in_data),
    .in_fire (in_valid && !in_stall),
    .ent     (f_ent),
    .push    (push)
  );

  mth_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (f_ent),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_ent    (q_ent)
  );

  mth_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ent     (q_ent),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .status    (bk_status)
  );

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.held_count <= CW'(MAX_HELD))
    else $error("held count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (bk_status.held_count == $past(bk_status.held_count) ||
         bk_status.held_count == $past(bk_status.held_count) + CW'(1) ||
         bk_status.held_count + CW'(1) == $past(bk_status.held_count)))
    else $error("held count jumped");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid && !bk_status.busy)
    else $error("queue popped while engine busy or queue empty");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import mth_pkg::*;

  class note_scoreboard;
    logic [7:0] held_nt [MAX_HELD];
    logic [7:0] held_st [MAX_HELD];
    logic [7:0] held_vl [MAX_HELD];
    int held_cnt;
    logic signed [7:0] cur_shift;
    out_item_t pending[$];
    int errors;

    function void clear();
      held_cnt = 0;
      cur_shift = '0;
      pending.delete();
      errors = 0;
    endfunction

    function void emit(logic [7:0] st, logic [7:0] d1, logic [7:0] d2, logic [1:0] len);
      out_item_t r;
      r.out_status = st;
      r.out_data_one = d1;
      r.out_data_two = d2;
      r.out_length = len;
      r.last_of_run = 1'b0;
      pending.push_back(r);
    endfunction

    function void note_input(in_item_t it);
      int base;
      int i;
      int nt;
      int nsh;
      logic [7:0] d1;
      logic [7:0] d2;
      logic [3:0] kind;
      bit is_note;
      base = pending.size();
      d1 = it.data_one;
      d2 = it.data_two;
      kind = it.status_byte[7:4];
      is_note = 0;
      if (it.cmd) begin
        nsh = it.transpose;
        if (nsh != int'(cur_shift)) begin
          for (i = 0; i < held_cnt; i++) begin
            nt = int'(held_nt[i]) + int'(cur_shift);
            if (nt >= 0 && nt <= 127) emit(held_st[i] & STATUS_OFF_MASK, nt[7:0], 8'd0, LEN_FULL);
          end
          for (i = 0; i < held_cnt; i++) begin
            nt = int'(held_nt[i]) + nsh;
            if (nt >= 0 && nt <= 127) emit(held_st[i], nt[7:0], held_vl[i], LEN_FULL);
          end
          cur_shift = it.transpose;
        end
      end else if (it.msg_length != LEN_NONE) begin
        if (it.msg_length < LEN_TWO) d1 = 8'd0;
        if (it.msg_length < LEN_FULL) d2 = 8'd0;
        if (kind == KIND_OFF || (kind == KIND_ON && d2 == 8'd0)) begin
          for (i = 0; i < held_cnt; i++) if (held_nt[i] == d1) break;
          if (i < held_cnt) begin
            for (; i + 1 < held_cnt; i++) begin
              held_nt[i] = held_nt[i + 1];
              held_st[i] = held_st[i + 1];
              held_vl[i] = held_vl[i + 1];
            end
            held_cnt--;
          end
          is_note = 1;
        end else if (kind == KIND_ON) begin
          for (i = 0; i < held_cnt; i++) if (held_nt[i] == d1) break;
          if (i == held_cnt && held_cnt < MAX_HELD) begin
            held_nt[held_cnt] = d1;
            held_st[held_cnt] = it.status_byte;
            held_vl[held_cnt] = d2;
            held_cnt++;
          end
          is_note = 1;
        end else if (kind == KIND_AT) begin
          is_note = 1;
        end
        nt = int'(d1) + int'(cur_shift);
        if (!is_note || (nt >= 0 && nt <= 127)) begin
          if (is_note) d1 = (it.msg_length >= LEN_TWO) ? nt[7:0] : 8'd0;
          emit(it.status_byte, d1, d2, it.msg_length);
        end
      end
      if (pending.size() > base) pending[pending.size() - 1].last_of_run = 1'b1;
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected item: %h", got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.out_status !== exp_r.out_status) begin
        $error("out_status expected %h actual %h", exp_r.out_status, got.out_status);
        errors++;
      end
      if (got.out_data_one !== exp_r.out_data_one) begin
        $error("out_data_one expected %h actual %h", exp_r.out_data_one, got.out_data_one);
        errors++;
      end
      if (got.out_data_two !== exp_r.out_data_two) begin
        $error("out_data_two expected %h actual %h", exp_r.out_data_two, got.out_data_two);
        errors++;
      end
      if (got.out_length !== exp_r.out_length) begin
        $error("out_length expected %h actual %h", exp_r.out_length, got.out_length);
        errors++;
      end
      if (got.last_of_run !== exp_r.last_of_run) begin
        $error("last_of_run expected %h actual %h", exp_r.last_of_run, got.last_of_run);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_data;

  note_scoreboard sb = new();
  bit calm = 0;
  bit hold_off = 0;
  int unsigned cycle_cnt = 0;

  midi_transposer_held_notes dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (!rst_n || hold_off) out_stall <= hold_off;
    else out_stall <= !calm && ($urandom_range(99) < 12);
  end

  task automatic send(in_item_t it);
    while (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
  endtask

  function automatic in_item_t mk_msg(logic [7:0] st, logic [7:0] d1, logic [7:0] d2,
                                      logic [1:0] len);
    in_item_t it;
    it.cmd = 1'b0;
    it.status_byte = st;
    it.data_one = d1;
    it.data_two = d2;
    it.msg_length = len;
    it.transpose = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t mk_xpose(logic [7:0] t);
    in_item_t it;
    it = mk_msg(8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom));
    it.cmd = 1'b1;
    it.transpose = t;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    int r;
    logic [7:0] kinds [4];
    kinds = '{8'h80, 8'h90, 8'hA0, 8'h90};
    r = $urandom_range(99);
    if (r < 8)
      return mk_xpose($urandom_range(99) < 70 ? 8'(int'($urandom_range(24)) - 12)
                                               : 8'($urandom));
    if (r < 80)
      return mk_msg(kinds[$urandom_range(3)] | 8'($urandom_range(15)),
                    $urandom_range(99) < 85 ? 8'(48 + $urandom_range(23)) : 8'($urandom),
                    $urandom_range(99) < 15 ? 8'd0 : 8'($urandom),
                    $urandom_range(99) < 85 ? LEN_FULL : 2'($urandom));
    return mk_msg(8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom));
  endfunction

  initial begin
    int i;
    sb.clear();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed
    send(mk_msg(8'h90, 8'd60, 8'd100, LEN_FULL));
    send(mk_msg(8'h91, 8'd0, 8'd127, LEN_FULL));
    send(mk_msg(8'h9F, 8'd127, 8'd255, LEN_FULL));
    send(mk_msg(8'h90, 8'd60, 8'd50, LEN_FULL));
    send(mk_xpose(8'sd5));
    send(mk_xpose(8'sd5));
    send(mk_msg(8'hA0, 8'd125, 8'd9, LEN_FULL));
    send(mk_xpose(8'h80));
    send(mk_msg(8'h90, 8'd255, 8'd1, LEN_FULL));
    send(mk_xpose(8'sd127));
    send(mk_msg(8'h80, 8'd200, 8'd0, LEN_FULL));
    send(mk_msg(8'h90, 8'd0, 8'd0, LEN_FULL));
    send(mk_msg(8'h80, 8'd77, 8'd3, LEN_FULL));
    send(mk_xpose(8'sd0));
    send(mk_msg(8'h90, 8'd61, 8'd99, LEN_TWO));
    send(mk_msg(8'h90, 8'd62, 8'd99, 2'd1));
    send(mk_msg(8'hC3, 8'hFF, 8'hFF, 2'd0));
    send(mk_msg(8'hFF, 8'hFF, 8'hFF, LEN_FULL));
    send(mk_msg(8'h00, 8'h00, 8'h00, 2'd1));
    for (i = 0; i < 18; i++) send(mk_msg(8'h90 | i[3:0], 8'(30 + i), 8'(i + 1), LEN_FULL));
    send(mk_xpose(8'hFD));
    for (i = 0; i < 60; i++) send(rand_item());
    calm = 1;
    for (i = 0; i < 40; i++) send(rand_item());
    calm = 0;
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      for (i = 0; i < 20; i++) send(rand_item());
    join
    for (i = 0; i < 160; i++) send(rand_item());
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
